>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the shading block
// Clocked concurrent checks, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is asserted
`define LSUW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that also holds across reset
`define LSUW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/lsuw_pkg.sv
// ---------------------------------------------------------------------------
// lsuw_pkg
// Shared types and constants of the Lambert shader and replicating writer.
// ---------------------------------------------------------------------------
package lsuw_pkg;

  // Default size limits
  localparam int MAX_FRAME_WIDTH_DEF  = 4096;
  localparam int MAX_FRAME_HEIGHT_DEF = 4096;
  localparam int MAX_SCALE_DEF        = 8;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Depth of the queue between shader and writer
  localparam int QUEUE_DEPTH = 4;

  // Shading constants: 0.15 and 0.85 of full gray 220, background 40
  localparam logic [7:0] AMBIENT_GRAY    = 8'd33;
  localparam logic [7:0] DIFFUSE_GRAY    = 8'd187;
  localparam logic [7:0] FULL_GRAY       = 8'd220;
  localparam logic [7:0] BACKGROUND_GRAY = 8'd40;

  // Register reset values
  localparam logic [15:0] LIGHT_X_RST      = 16'd16551;
  localparam logic [15:0] LIGHT_Y_RST      = 16'd9930;
  localparam logic [15:0] LIGHT_Z_RST      = 16'd26481;
  localparam logic [3:0]  SCALE_DIV_RST    = 4'd1;
  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd800;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd600;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_X      = 3'd0,
    CFG_LIGHT_Y      = 3'd1,
    CFG_LIGHT_Z      = 3'd2,
    CFG_SCALE_DIV    = 3'd3,
    CFG_FRAME_WIDTH  = 3'd4,
    CFG_FRAME_HEIGHT = 3'd5
  } lsuw_cfg_idx_t;

  // Register bank contents, raw as written
  typedef struct packed {
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic [3:0]         scale_divisor;
    logic [12:0]        frame_width;
    logic [12:0]        frame_height;
  } lsuw_cfg_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } lsuw_q_stat_t;

endpackage

>>> src/lsuw_fifo.sv
// ---------------------------------------------------------------------------
// lsuw_fifo
// Short queue of shaded items between the shader front and the writer back.
// ---------------------------------------------------------------------------
module lsuw_fifo #(
  parameter int DATA_W = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_W-1:0]    push_data,
  input  logic                 pop,
  output logic [DATA_W-1:0]    head_data,
  output lsuw_pkg::lsuw_q_stat_t stat
);
  import lsuw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_data  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/lsuw_front.sv
// ---------------------------------------------------------------------------
// lsuw_front
// Accepts hit records, shades them to a gray byte and forms the base frame
// coordinates of each replicated block, in a five-stage pipeline.
// ---------------------------------------------------------------------------
module lsuw_front #(
  parameter int MAX_SCALE = lsuw_pkg::MAX_SCALE_DEF,
  parameter int PX_W      = 12 + $clog2(MAX_SCALE + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lsuw_pkg::lsuw_cfg_t    cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_hit_valid,
  input  logic signed [15:0]     in_normal_x,
  input  logic signed [15:0]     in_normal_y,
  input  logic signed [15:0]     in_normal_z,
  input  logic [11:0]            in_render_col,
  input  logic [11:0]            in_render_row,
  input  lsuw_pkg::lsuw_q_stat_t q_stat,
  output logic                   push,
  output logic [7:0]             push_gray,
  output logic [PX_W-1:0]        push_px0,
  output logic [PX_W-1:0]        push_py0
);
  import lsuw_pkg::*;

  localparam int DV_W = $clog2(MAX_SCALE + 1);

  logic            en;
  logic [DV_W-1:0] div_eff;

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  // hit flags
  logic h1_r, h2_r, h3_r, h4_r;
  // base coordinates travel alongside
  logic [PX_W-1:0] px1_r, px2_r, px3_r, px4_r, px5_r;
  logic [PX_W-1:0] py1_r, py2_r, py3_r, py4_r, py5_r;
  // shading datapath
  logic signed [31:0] prx1_r, pry1_r, prz1_r;
  logic signed [33:0] dot2_r;
  logic [31:0]        mag3_r;
  logic [39:0]        dif4_r;
  logic [7:0]         gray5_r, gray5_nxt;
  logic [9:0]         gsum;

  // whole pipeline stalls only when a finished item cannot enter the queue
  assign en       = !(v5_r && q_stat.full);
  assign in_ready = en;
  assign push     = en && v5_r;
  assign push_gray = gray5_r;
  assign push_px0  = px5_r;
  assign push_py0  = py5_r;

  // replication factor, zero taken as one, saturated at the maximum
  always_comb begin
    if (cfg.scale_divisor == '0) begin
      div_eff = DV_W'(1);
    end else if (32'(cfg.scale_divisor) > 32'(MAX_SCALE)) begin
      div_eff = DV_W'(MAX_SCALE);
    end else begin
      div_eff = DV_W'(cfg.scale_divisor);
    end
  end

  // ambient plus diffuse, clamped at full gray; background gray for a miss
  always_comb begin
    gsum = 10'(dif4_r[39:30]) + 10'(AMBIENT_GRAY);
    if (!h4_r) begin
      gray5_nxt = BACKGROUND_GRAY;
    end else if (gsum > 10'(FULL_GRAY)) begin
      gray5_nxt = FULL_GRAY;
    end else begin
      gray5_nxt = gsum[7:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // products of normal and light, block origin
      prx1_r <= 32'(in_normal_x) * 32'(cfg.light_x);
      pry1_r <= 32'(in_normal_y) * 32'(cfg.light_y);
      prz1_r <= 32'(in_normal_z) * 32'(cfg.light_z);
      px1_r  <= PX_W'(in_render_col) * PX_W'(div_eff);
      py1_r  <= PX_W'(in_render_row) * PX_W'(div_eff);
      h1_r   <= in_hit_valid;
      // dot product
      dot2_r <= 34'(prx1_r) + 34'(pry1_r) + 34'(prz1_r);
      h2_r   <= h1_r;
      px2_r  <= px1_r;
      py2_r  <= py1_r;
      // magnitude, two-sided
      mag3_r <= dot2_r[33] ? 32'(-dot2_r) : 32'(dot2_r);
      h3_r   <= h2_r;
      px3_r  <= px2_r;
      py3_r  <= py2_r;
      // diffuse scale
      dif4_r <= 40'(mag3_r) * 40'(DIFFUSE_GRAY);
      h4_r   <= h3_r;
      px4_r  <= px3_r;
      py4_r  <= py3_r;
      // final gray
      gray5_r <= gray5_nxt;
      px5_r   <= px4_r;
      py5_r   <= py4_r;
    end
  end

endmodule

>>> src/lsuw_back.sv
// ---------------------------------------------------------------------------
// lsuw_back
// Walks each queued item over its scale-by-scale block, row by row, and
// produces frame writes with a flipped row index and an in-frame flag.
// ---------------------------------------------------------------------------
module lsuw_back #(
  parameter int MAX_FRAME_WIDTH  = lsuw_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT = lsuw_pkg::MAX_FRAME_HEIGHT_DEF,
  parameter int MAX_SCALE        = lsuw_pkg::MAX_SCALE_DEF,
  parameter int PX_W             = 12 + $clog2(MAX_SCALE + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lsuw_pkg::lsuw_cfg_t    cfg,
  input  lsuw_pkg::lsuw_q_stat_t q_stat,
  input  logic [7:0]             head_gray,
  input  logic [PX_W-1:0]        head_px0,
  input  logic [PX_W-1:0]        head_py0,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [23:0]            out_pixel_index,
  output logic [7:0]             out_gray_level,
  output logic                   out_in_frame,
  output logic                   out_last_write
);
  import lsuw_pkg::*;

  localparam int DV_W   = $clog2(MAX_SCALE + 1);
  localparam int SC_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int WW     = $clog2(MAX_FRAME_WIDTH + 1);
  localparam int HW     = $clog2(MAX_FRAME_HEIGHT + 1);
  localparam int CMP_W  = ((PX_W > WW) ? ((PX_W > HW) ? PX_W : HW)
                                       : ((WW > HW) ? WW : HW)) + 1;
  localparam int PROD_W = HW + WW;
  localparam int SUM_W  = ((PROD_W > PX_W) ? PROD_W : PX_W) + 1;

  logic            en, gen_valid, gen_last, gen_inside;
  logic [DV_W-1:0] div_eff;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [SC_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [PX_W-1:0] gen_px, gen_py;
  logic [HW-1:0]   gen_rflip;

  // generate stage
  logic            s1_valid_r;
  logic            s1_last_r, s1_inside_r;
  logic [7:0]      s1_gray_r;
  logic [PX_W-1:0] s1_px_r;
  logic [HW-1:0]   s1_rflip_r;

  // output register
  logic              out_valid_r;
  logic [23:0]       out_index_r;
  logic [7:0]        out_gray_r;
  logic              out_in_frame_r, out_last_r;
  logic [PROD_W-1:0] row_base;
  logic [SUM_W-1:0]  idx_sum;

  assign en        = !out_valid_r || out_ready;
  assign gen_valid = !q_stat.empty;
  assign pop       = en && gen_valid && gen_last;

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_index_r;
  assign out_gray_level  = out_gray_r;
  assign out_in_frame    = out_in_frame_r;
  assign out_last_write  = out_last_r;

  // effective geometry: zero taken as one, saturated at the maxima
  always_comb begin
    if (cfg.scale_divisor == '0) begin
      div_eff = DV_W'(1);
    end else if (32'(cfg.scale_divisor) > 32'(MAX_SCALE)) begin
      div_eff = DV_W'(MAX_SCALE);
    end else begin
      div_eff = DV_W'(cfg.scale_divisor);
    end
    if (cfg.frame_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg.frame_width) > 32'(MAX_FRAME_WIDTH)) begin
      w_eff = WW'(MAX_FRAME_WIDTH);
    end else begin
      w_eff = WW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg.frame_height) > 32'(MAX_FRAME_HEIGHT)) begin
      h_eff = HW'(MAX_FRAME_HEIGHT);
    end else begin
      h_eff = HW'(cfg.frame_height);
    end
  end

  // current write of the block at the queue head
  always_comb begin
    gen_px     = head_px0 + PX_W'(dx_r);
    gen_py     = head_py0 + PX_W'(dy_r);
    gen_last   = (DV_W'(dx_r) == div_eff - DV_W'(1)) &&
                 (DV_W'(dy_r) == div_eff - DV_W'(1));
    gen_inside = (CMP_W'(gen_px) < CMP_W'(w_eff)) && (CMP_W'(gen_py) < CMP_W'(h_eff));
    gen_rflip  = HW'(CMP_W'(h_eff) - CMP_W'(1) - CMP_W'(gen_py));
  end

  // block walk: dx inner, dy outer
  always_comb begin
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    if (en && gen_valid) begin
      if (gen_last) begin
        dx_nxt = '0;
        dy_nxt = '0;
      end else if (DV_W'(dx_r) == div_eff - DV_W'(1)) begin
        dx_nxt = '0;
        dy_nxt = dy_r + SC_W'(1);
      end else begin
        dx_nxt = dx_r + SC_W'(1);
      end
    end
  end

  // frame index of the staged write
  always_comb begin
    row_base = PROD_W'(s1_rflip_r) * PROD_W'(w_eff);
    idx_sum  = SUM_W'(row_base) + SUM_W'(s1_px_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r        <= '0;
      dy_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      if (en) begin
        s1_valid_r  <= gen_valid;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last_r   <= gen_last;
      s1_inside_r <= gen_inside;
      s1_gray_r   <= head_gray;
      s1_px_r     <= gen_px;
      s1_rflip_r  <= gen_rflip;
      out_index_r    <= s1_inside_r ? 24'(idx_sum) : '0;
      out_gray_r     <= s1_inside_r ? s1_gray_r : '0;
      out_in_frame_r <= s1_inside_r;
      out_last_r     <= s1_last_r;
    end
  end

endmodule

>>> src/lambert_shade_upscale_writer_top.sv
// ---------------------------------------------------------------------------
// lambert_shade_upscale_writer_top
// Two-sided Lambertian shader with ambient floor feeding a replicating
// frame writer; shader and writer are decoupled by a short queue.
// ---------------------------------------------------------------------------
//  channel | signals                          | transfer when
//  --------+----------------------------------+----------------------------
//  input   | in_valid/in_ready, hit record    | in_valid && in_ready
//  result  | out_valid/out_ready, frame write | out_valid && out_ready
//  config  | cfg_we, cfg_index, cfg_data      | cfg_we (no wait)
//
//  Each input gives scale_divisor squared writes, one per cycle unless the
//  output stalls, so the writer loop sets the rate: one input per cycle at
//  full resolution. Path: five shader stages, the queue, two writer stages.
//  Reset is synchronous, active low; no clearing pass.
//  A stalled output holds the writer; the queue then fills and the shader
//  stops taking inputs only when its last stage cannot enter the queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lambert_shade_upscale_writer_top #(
  parameter int MAX_FRAME_WIDTH  = lsuw_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT = lsuw_pkg::MAX_FRAME_HEIGHT_DEF,
  parameter int MAX_SCALE        = lsuw_pkg::MAX_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsuw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsuw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_hit_valid,
  input  logic signed [15:0]             in_normal_x,
  input  logic signed [15:0]             in_normal_y,
  input  logic signed [15:0]             in_normal_z,
  input  logic [11:0]                    in_render_col,
  input  logic [11:0]                    in_render_row,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [23:0]                    out_pixel_index,
  output logic [7:0]                     out_gray_level,
  output logic                           out_in_frame,
  output logic                           out_last_write
);
  import lsuw_pkg::*;

  localparam int PX_W   = 12 + $clog2(MAX_SCALE + 1);
  localparam int ITEM_W = 8 + 2 * PX_W;

  lsuw_cfg_t    cfg_r, cfg_nxt;
  lsuw_q_stat_t q_stat;
  logic              push, pop;
  logic [7:0]        push_gray, head_gray;
  logic [PX_W-1:0]   push_px0, push_py0, head_px0, head_py0;
  logic [ITEM_W-1:0] head_item;

  // register bank write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LIGHT_X:      cfg_nxt.light_x       = cfg_data;
        CFG_LIGHT_Y:      cfg_nxt.light_y       = cfg_data;
        CFG_LIGHT_Z:      cfg_nxt.light_z       = cfg_data;
        CFG_SCALE_DIV:    cfg_nxt.scale_divisor = cfg_data[3:0];
        CFG_FRAME_WIDTH:  cfg_nxt.frame_width   = cfg_data[12:0];
        CFG_FRAME_HEIGHT: cfg_nxt.frame_height  = cfg_data[12:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_x       <= LIGHT_X_RST;
      cfg_r.light_y       <= LIGHT_Y_RST;
      cfg_r.light_z       <= LIGHT_Z_RST;
      cfg_r.scale_divisor <= SCALE_DIV_RST;
      cfg_r.frame_width   <= FRAME_WIDTH_RST;
      cfg_r.frame_height  <= FRAME_HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // shader front
  lsuw_front #(
    .MAX_SCALE (MAX_SCALE),
    .PX_W      (PX_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hit_valid  (in_hit_valid),
    .in_normal_x   (in_normal_x),
    .in_normal_y   (in_normal_y),
    .in_normal_z   (in_normal_z),
    .in_render_col (in_render_col),
    .in_render_row (in_render_row),
    .q_stat        (q_stat),
    .push          (push),
    .push_gray     (push_gray),
    .push_px0      (push_px0),
    .push_py0      (push_py0)
  );

  // item queue
  lsuw_fifo #(
    .DATA_W (ITEM_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_gray, push_px0, push_py0}),
    .pop       (pop),
    .head_data (head_item),
    .stat      (q_stat)
  );

  assign head_gray = head_item[ITEM_W-1 -: 8];
  assign head_px0  = head_item[2*PX_W-1 -: PX_W];
  assign head_py0  = head_item[PX_W-1:0];

  // replicating writer back
  lsuw_back #(
    .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT),
    .MAX_SCALE        (MAX_SCALE),
    .PX_W             (PX_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_stat          (q_stat),
    .head_gray       (head_gray),
    .head_px0        (head_px0),
    .head_py0        (head_py0),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_gray_level  (out_gray_level),
    .out_in_frame    (out_in_frame),
    .out_last_write  (out_last_write)
  );

  // checks
  `LSUW_ASSERT(a_no_overflow, push |-> !q_stat.full, "queue push while full")
  `LSUW_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")
  `LSUW_ASSERT(a_outside_zero, (out_valid && !out_in_frame) |-> (out_pixel_index == 24'd0 && out_gray_level == 8'd0), "off-frame write carries data")
  `LSUW_ASSERT(a_gray_range, (out_valid && out_in_frame) |-> (out_gray_level >= AMBIENT_GRAY && out_gray_level <= FULL_GRAY), "gray outside shading range")

endmodule

>>> dv/lambert_shade_upscale_writer_top_tb.sv
// ---------------------------------------------------------------------------
// lambert_shade_upscale_writer_top_tb
// Self-checking bench for the Lambert shader and replicating frame writer.
// Drives ray-hit records through several register settings, predicts every
// replicated frame write, and checks each output transfer in order.
// ---------------------------------------------------------------------------
module lambert_shade_upscale_writer_top_tb;
  import lsuw_pkg::*;

  // Index codes past the register list; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 16;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [11:0]        col;
    logic [11:0]        row;
  } hit_rec_t;

  typedef struct packed {
    logic [23:0] pixel_index;
    logic [7:0]  gray_level;
    logic        in_frame;
    logic        last_write;
  } frame_write_t;

  // Expected frame writes, derived from hit records and the register copy
  class frame_write_board;
    logic signed [15:0] light_x, light_y, light_z;
    logic [3:0]         div_raw;
    logic [12:0]        width_raw, height_raw;
    frame_write_t       expected_writes[$];
    int                 mismatches;

    function new();
      light_x    = LIGHT_X_RST;
      light_y    = LIGHT_Y_RST;
      light_z    = LIGHT_Z_RST;
      div_raw    = SCALE_DIV_RST;
      width_raw  = FRAME_WIDTH_RST;
      height_raw = FRAME_HEIGHT_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LIGHT_X:      light_x    = data;
        CFG_LIGHT_Y:      light_y    = data;
        CFG_LIGHT_Z:      light_z    = data;
        CFG_SCALE_DIV:    div_raw    = data[3:0];
        CFG_FRAME_WIDTH:  width_raw  = data[12:0];
        CFG_FRAME_HEIGHT: height_raw = data[12:0];
        default: ;
      endcase
    endfunction

    // Zero reads as one, oversize saturates
    function int eff_div();
      if (div_raw == 0) return 1;
      if (div_raw > MAX_SCALE_DEF) return MAX_SCALE_DEF;
      return int'(div_raw);
    endfunction

    function int eff_width();
      if (width_raw == 0) return 1;
      if (width_raw > MAX_FRAME_WIDTH_DEF) return MAX_FRAME_WIDTH_DEF;
      return int'(width_raw);
    endfunction

    function int eff_height();
      if (height_raw == 0) return 1;
      if (height_raw > MAX_FRAME_HEIGHT_DEF) return MAX_FRAME_HEIGHT_DEF;
      return int'(height_raw);
    endfunction

    // Ambient 33 plus 187 * |n.l| in Q3.30, clamped at full gray; background gray for a miss
    function logic [7:0] shade_gray(hit_rec_t r);
      longint dot, mag, g;
      if (!r.hit) return BACKGROUND_GRAY;
      dot = longint'(r.nx) * longint'(light_x) + longint'(r.ny) * longint'(light_y)
          + longint'(r.nz) * longint'(light_z);
      mag = (dot < 0) ? -dot : dot;
      g = longint'(AMBIENT_GRAY) + ((longint'(DIFFUSE_GRAY) * mag) >> 30);
      if (g > longint'(FULL_GRAY)) g = longint'(FULL_GRAY);
      return g[7:0];
    endfunction

    // One accepted hit record expands into div x div writes, dy outer
    function void add_hit(hit_rec_t r);
      int d, w, h, px, py;
      logic [7:0] gray;
      frame_write_t fw;
      d    = eff_div();
      w    = eff_width();
      h    = eff_height();
      gray = shade_gray(r);
      for (int dy = 0; dy < d; dy++) begin
        for (int dx = 0; dx < d; dx++) begin
          px = int'(r.col) * d + dx;
          py = int'(r.row) * d + dy;
          fw.in_frame    = (px < w) && (py < h);
          fw.pixel_index = fw.in_frame ? 24'((h - 1 - py) * w + px) : '0;
          fw.gray_level  = fw.in_frame ? gray : '0;
          fw.last_write  = (dy == d - 1) && (dx == d - 1);
          expected_writes.push_back(fw);
        end
      end
    endfunction

    function void check_write(frame_write_t got);
      frame_write_t want;
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected frame write: idx=%0d gray=%0d in=%0b last=%0b",
                   got.pixel_index, got.gray_level, got.in_frame, got.last_write);
        return;
      end
      want = expected_writes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("frame write mismatch: exp idx=%0d gray=%0d in=%0b last=%0b",
                   want.pixel_index, want.gray_level, want.in_frame, want.last_write);
          $display("                      got idx=%0d gray=%0d in=%0b last=%0b",
                   got.pixel_index, got.gray_level, got.in_frame, got.last_write);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_hit_valid = 1'b0;
  logic signed [15:0]    in_normal_x = '0;
  logic signed [15:0]    in_normal_y = '0;
  logic signed [15:0]    in_normal_z = '0;
  logic [11:0]           in_render_col = '0;
  logic [11:0]           in_render_row = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [23:0]           out_pixel_index;
  logic [7:0]            out_gray_level;
  logic                  out_in_frame;
  logic                  out_last_write;

  frame_write_board sb = new();
  frame_write_t     seen_write;
  hit_rec_t         seen_hit;
  bit               sender_idles = 1'b1;
  bit               receiver_idles = 1'b1;
  bit               long_hold = 1'b0;
  int               stuck_cycles = 0;

  lambert_shade_upscale_writer_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_hit_valid    (in_hit_valid),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_render_col   (in_render_col),
    .in_render_row   (in_render_row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_gray_level  (out_gray_level),
    .out_in_frame    (out_in_frame),
    .out_last_write  (out_last_write)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic hit_rec_t hit_rec(logic hit, logic signed [15:0] nx,
                                       logic signed [15:0] ny, logic signed [15:0] nz,
                                       logic [11:0] col, logic [11:0] row);
    hit_rec_t r;
    r.hit = hit;
    r.nx  = nx;
    r.ny  = ny;
    r.nz  = nz;
    r.col = col;
    r.row = row;
    return r;
  endfunction

  // Normals of random magnitude so gray levels spread below the clamp
  function automatic logic signed [15:0] rand_comp();
    logic signed [15:0] v;
    v = 16'($urandom);
    if ($urandom_range(0, 3) != 0) v = v >>> $urandom_range(1, 6);
    return v;
  endfunction

  // Coordinates mostly land on or just past the frame, a few anywhere
  function automatic hit_rec_t rand_hit();
    hit_rec_t r;
    int d, cmax, rmax;
    d    = sb.eff_div();
    cmax = (sb.eff_width() + d - 1) / d;
    rmax = (sb.eff_height() + d - 1) / d;
    if (cmax > 4095) cmax = 4095;
    if (rmax > 4095) rmax = 4095;
    r.hit = ($urandom_range(0, 99) < 80);
    r.nx  = rand_comp();
    r.ny  = rand_comp();
    r.nz  = rand_comp();
    if ($urandom_range(0, 9) < 8) begin
      r.col = 12'($urandom_range(0, cmax));
      r.row = 12'($urandom_range(0, rmax));
    end else begin
      r.col = 12'($urandom_range(0, 4095));
      r.row = 12'($urandom_range(0, 4095));
    end
    return r;
  endfunction

  // Offer one hit record and hold it until the transfer
  task automatic send_hit(hit_rec_t r);
    int gap;
    gap = pick_gap(sender_idles);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hit_valid  <= r.hit;
    in_normal_x   <= r.nx;
    in_normal_y   <= r.ny;
    in_normal_z   <= r.nz;
    in_render_col <= r.col;
    in_render_row <= r.row;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(int n);
    repeat (n) send_hit(rand_hit());
  endtask

  // Stop offering, then wait for every expected write plus settle time
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Program all registers back to back; junk sits in unused upper bits
  task automatic apply_settings(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
                                logic [3:0] div, logic [12:0] w, logic [12:0] h);
    logic [15:0] junk;
    junk = 16'($urandom);
    put_reg(CFG_LIGHT_X, lx);
    put_reg(CFG_LIGHT_Y, ly);
    put_reg(CFG_LIGHT_Z, lz);
    put_reg(CFG_SCALE_DIV, {junk[15:4], div});
    put_reg(CFG_FRAME_WIDTH, {junk[15:13], w});
    put_reg(CFG_FRAME_HEIGHT, {~junk[15:13], h});
    put_reg(CFG_SPARE_LO, 16'($urandom));
    put_reg(CFG_SPARE_HI, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Scoreboard taps: note input transfers, check output transfers
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      seen_hit = hit_rec(in_hit_valid, in_normal_x, in_normal_y, in_normal_z,
                         in_render_col, in_render_row);
      sb.add_hit(seen_hit);
    end
    if (rst_n && out_valid && out_ready) begin
      seen_write.pixel_index = out_pixel_index;
      seen_write.gray_level  = out_gray_level;
      seen_write.in_frame    = out_in_frame;
      seen_write.last_write  = out_last_write;
      sb.check_write(seen_write);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: random ready pattern, one long hold-off on request
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (!receiver_idles) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        gap = pick_gap(1'b1);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed records under reset settings (div 1, 800 x 600)
    send_hit(hit_rec(1'b0, 16'sd0, 16'sd0, 16'sd0, 12'd0, 12'd0));
    send_hit(hit_rec(1'b0, -16'sd32768, 16'sd32767, -16'sd1, 12'd5, 12'd7));
    send_hit(hit_rec(1'b1, 16'sd0, 16'sd0, 16'sd0, 12'd1, 12'd1));
    send_hit(hit_rec(1'b1, 16'sd16551, 16'sd9930, 16'sd26481, 12'd2, 12'd3));
    send_hit(hit_rec(1'b1, -16'sd16551, -16'sd9930, -16'sd26481, 12'd3, 12'd2));
    send_hit(hit_rec(1'b1, -16'sd32768, -16'sd32768, -16'sd32768, 12'd10, 12'd10));
    send_hit(hit_rec(1'b1, 16'sd32767, 16'sd32767, 16'sd32767, 12'd11, 12'd10));
    send_hit(hit_rec(1'b1, 16'sd32767, 16'sd0, 16'sd0, 12'd12, 12'd10));
    send_hit(hit_rec(1'b1, -16'sd32768, 16'sd0, 16'sd0, 12'd13, 12'd10));
    send_hit(hit_rec(1'b1, 16'sd0, -16'sd32768, 16'sd0, 12'd14, 12'd10));
    send_hit(hit_rec(1'b1, 16'sd0, 16'sd0, 16'sd32767, 12'd15, 12'd10));
    send_hit(hit_rec(1'b1, 16'sd1, -16'sd1, 16'sd1, 12'd16, 12'd10));
    send_hit(hit_rec(1'b1, 16'sd2000, -16'sd3000, 16'sd1000, 12'd17, 12'd10));
    // Frame corners and just outside
    send_hit(hit_rec(1'b1, 16'sd8000, 16'sd8000, 16'sd8000, 12'd799, 12'd599));
    send_hit(hit_rec(1'b1, 16'sd8000, 16'sd8000, 16'sd8000, 12'd799, 12'd0));
    send_hit(hit_rec(1'b1, 16'sd8000, 16'sd8000, 16'sd8000, 12'd0, 12'd599));
    send_hit(hit_rec(1'b1, 16'sd8000, 16'sd8000, 16'sd8000, 12'd800, 12'd0));
    send_hit(hit_rec(1'b1, 16'sd8000, 16'sd8000, 16'sd8000, 12'd0, 12'd600));
    send_hit(hit_rec(1'b0, 16'sd0, 16'sd0, 16'sd0, 12'd4095, 12'd0));
    send_hit(hit_rec(1'b1, 16'sd100, 16'sd100, 16'sd100, 12'd0, 12'd4095));
    send_hit(hit_rec(1'b1, -16'sd1, -16'sd1, -16'sd1, 12'd4095, 12'd4095));
    send_random(40);
    drain();

    // Zero settings: div 1, 1 x 1 frame, most negative light
    apply_settings(16'h8000, 16'h8000, 16'h8000, 4'd0, 13'd0, 13'd0);
    send_random(50);
    drain();

    // Largest sizes with no idling on either side
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    apply_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 4'd8, 13'd4096, 13'd4096);
    send_random(30);
    drain();

    // Oversize values saturate
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                   4'd15, 13'd8191, 13'd5000);
    send_random(25);
    drain();

    // Receiver holds off while the sender keeps offering back to back
    sender_idles = 1'b0;
    apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 4'd2,
                   13'($urandom_range(16, 300)), 13'($urandom_range(16, 300)));
    long_hold = 1'b1;
    send_random(80);
    drain();
    sender_idles = 1'b1;

    // Random settings, small scale factors mostly
    for (int ph = 0; ph < 4; ph++) begin
      apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                     4'((ph == 3) ? $urandom_range(4, 8) : $urandom_range(1, 3)),
                     13'($urandom_range(1, 1200)), 13'($urandom_range(1, 1200)));
      send_random(60);
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_writes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.expected_writes.size() != 0)
        $display("%0d expected frame writes never arrived", sb.expected_writes.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/lsuw_pkg.sv
src/lsuw_fifo.sv
src/lsuw_front.sv
src/lsuw_back.sv
src/lambert_shade_upscale_writer_top.sv
dv/lambert_shade_upscale_writer_top_tb.sv
